FILE: src/mbet_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared types, constants and helpers for the escape-time pixel evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package mbet_pkg;

  // Field and format widths.
  localparam int COORD_W  = 32;
  localparam int PROD_W   = 64;
  localparam int ITER_W   = 7;
  localparam int TAG_W    = 5;
  localparam int CFG_IDX_W = 4;

  // Algorithm constants.
  localparam logic [ITER_W-1:0] MAX_ITER    = 7'd64;
  localparam logic [ITER_W-1:0] BLACK_VALUE = 7'd0;
  localparam logic [TAG_W-1:0]  WORKERS     = 5'd4;
  // The escape radius squared, 4.0 in Q8.56.
  localparam logic [PROD_W-1:0] FOUR_Q56    = 64'h0400_0000_0000_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_RE = 4'd0,
    REG_ORIGIN_IM = 4'd1,
    REG_STEP_RE   = 4'd2,
    REG_STEP_IM   = 4'd3
  } cfg_reg_t;

  // Input request payload.
  typedef struct packed {
    logic [7:0] pixel_col;
    logic [7:0] pixel_row;
    logic [3:0] worker_id;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic [ITER_W-1:0] iter_value;
    logic [TAG_W-1:0]  owner_tag;
  } out_t;

  // Current view window, Q4.28.
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_re;
    logic signed [COORD_W-1:0] origin_im;
    logic signed [COORD_W-1:0] step_re;
    logic signed [COORD_W-1:0] step_im;
  } cfg_t;

  // Operands of the shared multiplier set.
  typedef struct packed {
    logic signed [COORD_W-1:0] a0;
    logic signed [COORD_W-1:0] b0;
    logic signed [COORD_W-1:0] a1;
    logic signed [COORD_W-1:0] b1;
    logic signed [COORD_W-1:0] a2;
    logic signed [COORD_W-1:0] b2;
  } mul_op_t;

  // Registered products of the shared multiplier set.
  typedef struct packed {
    logic signed [PROD_W-1:0] p0;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;
  } mul_res_t;

  // Clamp a 42-bit signed value to the 32-bit signed range.
  function automatic logic [COORD_W-1:0] sat32(input logic [41:0] v);
    logic fits;
    fits = (v[41:31] == {11{v[41]}});
    if (fits) begin
      return v[31:0];
    end else if (v[41]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7fff_ffff;
    end
  endfunction

endpackage

`default_nettype wire

FILE: src/mbet_cfg_regs.sv
// ----------------------------------------------------------------------------
// Mandelbrot configuration registers
// Holds the view origin and pixel spacing, written through a plain port.
// ----------------------------------------------------------------------------
`default_nettype none

module mbet_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [mbet_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mbet_pkg::COORD_W-1:0]   cfg_data,
  output mbet_pkg::cfg_t                      cfg_o
);

  mbet_pkg::cfg_t cfg_r;
  mbet_pkg::cfg_t cfg_nxt;

  // Decode the write; indexes past the register list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mbet_pkg::REG_ORIGIN_RE: cfg_nxt.origin_re = cfg_data;
        mbet_pkg::REG_ORIGIN_IM: cfg_nxt.origin_im = cfg_data;
        mbet_pkg::REG_STEP_RE:   cfg_nxt.step_re   = cfg_data;
        mbet_pkg::REG_STEP_IM:   cfg_nxt.step_im   = cfg_data;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  // Reset shows the full default view.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_re <= -32'sd536870912;
      cfg_r.origin_im <= 32'sd536870912;
      cfg_r.step_re   <= 32'sd4210752;
      cfg_r.step_im   <= 32'sd4210752;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

FILE: src/mbet_mul_unit.sv
// ----------------------------------------------------------------------------
// Mandelbrot shared multiplier set
// Three signed 32x32 multipliers with registered 64-bit products.
// ----------------------------------------------------------------------------
`default_nettype none

module mbet_mul_unit (
  input  wire logic              clk,
  input  wire mbet_pkg::mul_op_t op_i,
  output mbet_pkg::mul_res_t     res_o
);

  mbet_pkg::mul_res_t res_r;
  mbet_pkg::mul_res_t res_nxt;

  // Full-precision products; the sequencer picks the operands.
  always_comb begin
    res_nxt.p0 = $signed(op_i.a0) * $signed(op_i.b0);
    res_nxt.p1 = $signed(op_i.a1) * $signed(op_i.b1);
    res_nxt.p2 = $signed(op_i.a2) * $signed(op_i.b2);
  end

  // Products are payload only and need no reset.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

`default_nettype wire

FILE: src/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel evaluator
// Maps a raster pixel to c and runs the z = z^2 + c escape-time loop.
// ----------------------------------------------------------------------------
// A request on the in_ channel carries a pixel column, row and worker tag.
// The view window is set through the cfg_ port (write enable, index, data);
// the user must write it only while no pixel is in flight (not enforced).
// One result leaves on the out_ channel per request: the remaining count at
// escape, MAX_ITER for a pixel that never escapes, or the black value tagged
// WORKERS when c already lies outside radius two.
// Coordinate mapping runs through a multiply state and then a map state.
// Each check of |z|^2 runs through a multiply state on the shared
// three-multiplier unit, then a compare-and-update state, and a done state
// then loads the output register. A pixel takes 1 to MAX_ITER+1 checks, and
// the next request is taken once the sequencer is back in idle. One pixel is
// worked on at a time.
// The next request is taken while a finished result still waits in the
// output register; if the receiver stalls longer, the block holds its next
// result and stops taking requests until the output register frees up.
// Reset returns the sequencer to idle, empties the output register and
// loads the default view window.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_pixel (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire mbet_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output mbet_pkg::out_t                      out_data,
  input  wire logic                           cfg_we,
  input  wire logic [mbet_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mbet_pkg::COORD_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_CMAP,
    S_SQ,
    S_CHK,
    S_DONE
  } state_t;

  mbet_pkg::cfg_t     cfg;
  mbet_pkg::mul_op_t  mul_op;
  mbet_pkg::mul_res_t mul_res;

  state_t state_r, state_nxt;
  logic [7:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;
  logic [3:0] tag_r, tag_nxt;
  logic signed [mbet_pkg::COORD_W-1:0] c_re_r, c_re_nxt;
  logic signed [mbet_pkg::COORD_W-1:0] c_im_r, c_im_nxt;
  logic signed [mbet_pkg::COORD_W-1:0] z_re_r, z_re_nxt;
  logic signed [mbet_pkg::COORD_W-1:0] z_im_r, z_im_nxt;
  logic [mbet_pkg::ITER_W-1:0] cnt_r, cnt_nxt;
  logic first_r, first_nxt;
  mbet_pkg::out_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  mbet_pkg::out_t out_data_r, out_data_nxt;

  logic [41:0] map_re;
  logic [41:0] map_im;
  logic [mbet_pkg::PROD_W-1:0] mag;
  logic escape;
  logic [mbet_pkg::PROD_W-1:0] sq_diff;
  logic [41:0] upd_re;
  logic [41:0] upd_im;

  mbet_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  mbet_mul_unit u_mul (
    .clk   (clk),
    .op_i  (mul_op),
    .res_o (mul_res)
  );

  // Coordinate mapping from the registered pixel-times-step products.
  assign map_re = {{10{cfg.origin_re[31]}}, cfg.origin_re} + mul_res.p0[41:0];
  assign map_im = {{10{cfg.origin_im[31]}}, cfg.origin_im} - mul_res.p1[41:0];

  // Escape test on the exact sum of squares, strict greater-than.
  assign mag    = $unsigned(mul_res.p0) + $unsigned(mul_res.p1);
  assign escape = (mag > mbet_pkg::FOUR_Q56);

  // Next iterate: the upper bits of a product are a floor shift.
  assign sq_diff = mul_res.p0 - mul_res.p1;
  assign upd_re  = {{6{sq_diff[63]}}, sq_diff[63:28]} + {{10{c_re_r[31]}}, c_re_r};
  assign upd_im  = {{5{mul_res.p2[63]}}, mul_res.p2[63:27]} + {{10{c_im_r[31]}}, c_im_r};

  // Operand selection for the shared multipliers.
  always_comb begin
    mul_op = '0;
    unique case (state_r)
      S_MAP: begin
        mul_op.a0 = cfg.step_re;
        mul_op.b0 = {24'd0, col_r};
        mul_op.a1 = cfg.step_im;
        mul_op.b1 = {24'd0, row_r};
      end
      S_SQ: begin
        mul_op.a0 = z_re_r;
        mul_op.b0 = z_re_r;
        mul_op.a1 = z_im_r;
        mul_op.b1 = z_im_r;
        mul_op.a2 = z_re_r;
        mul_op.b2 = z_im_r;
      end
      default: mul_op = '0;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    tag_nxt       = tag_r;
    c_re_nxt      = c_re_r;
    c_im_nxt      = c_im_r;
    z_re_nxt      = z_re_r;
    z_im_nxt      = z_im_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // The receiver empties the output register.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          col_nxt   = in_data.pixel_col;
          row_nxt   = in_data.pixel_row;
          tag_nxt   = in_data.worker_id;
          state_nxt = S_MAP;
        end
      end
      S_MAP: begin
        state_nxt = S_CMAP;
      end
      S_CMAP: begin
        c_re_nxt  = mbet_pkg::sat32(map_re);
        c_im_nxt  = mbet_pkg::sat32(map_im);
        z_re_nxt  = mbet_pkg::sat32(map_re);
        z_im_nxt  = mbet_pkg::sat32(map_im);
        cnt_nxt   = mbet_pkg::MAX_ITER;
        first_nxt = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (escape) begin
          // An escape on the very first check means c is outside radius two.
          if (first_r) begin
            res_nxt.iter_value = mbet_pkg::BLACK_VALUE;
            res_nxt.owner_tag  = mbet_pkg::WORKERS;
          end else begin
            res_nxt.iter_value = cnt_r;
            res_nxt.owner_tag  = {1'b0, tag_r};
          end
          state_nxt = S_DONE;
        end else if (cnt_r == '0) begin
          res_nxt.iter_value = mbet_pkg::MAX_ITER;
          res_nxt.owner_tag  = {1'b0, tag_r};
          state_nxt          = S_DONE;
        end else begin
          z_re_nxt  = mbet_pkg::sat32(upd_re);
          z_im_nxt  = mbet_pkg::sat32(upd_im);
          cnt_nxt   = cnt_r - 1'b1;
          first_nxt = 1'b0;
          state_nxt = S_SQ;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs; payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    tag_r      <= tag_nxt;
    c_re_r     <= c_re_nxt;
    c_im_r     <= c_im_nxt;
    z_re_r     <= z_re_nxt;
    z_im_r     <= z_im_nxt;
    cnt_r      <= cnt_nxt;
    first_r    <= first_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: verif/mandelbrot_escape_time_pixel_tb.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel testbench
// Drives pixel requests through several view windows and checks each escape
// count and owner tag against a cycle-free model of the iteration.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mandelbrot_escape_time_pixel_tb;

  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_AT       = 260;
  localparam int HOLD_CYCLES   = 600;
  localparam logic [mbet_pkg::CFG_IDX_W-1:0] FIRST_SPARE_REG =
    mbet_pkg::CFG_IDX_W'(mbet_pkg::REG_STEP_IM + 1);
  localparam logic [mbet_pkg::CFG_IDX_W-1:0] LAST_SPARE_REG  =
    {mbet_pkg::CFG_IDX_W{1'b1}};

  // Holds the view window and the escape results still owed by the block.
  class escape_scoreboard;
    localparam longint COORD_HI = (longint'(1) <<< 31) - 1;
    localparam longint COORD_LO = -(longint'(1) <<< 31);

    longint org_re;
    longint org_im;
    longint pitch_re;
    longint pitch_im;
    mbet_pkg::out_t pending_escapes[$];
    int     faults;

    function new();
      org_re   = -536870912;
      org_im   = 536870912;
      pitch_re = 4210752;
      pitch_im = 4210752;
      faults   = 0;
    endfunction

    function void set_register(input logic [mbet_pkg::CFG_IDX_W-1:0] idx,
                               input logic [mbet_pkg::COORD_W-1:0] data);
      longint v;
      v = longint'($signed(data));
      case (idx)
        mbet_pkg::REG_ORIGIN_RE: org_re   = v;
        mbet_pkg::REG_ORIGIN_IM: org_im   = v;
        mbet_pkg::REG_STEP_RE:   pitch_re = v;
        mbet_pkg::REG_STEP_IM:   pitch_im = v;
        default: ;
      endcase
    endfunction

    function longint clamp_q428(input longint v);
      if (v > COORD_HI) return COORD_HI;
      if (v < COORD_LO) return COORD_LO;
      return v;
    endfunction

    // Strict comparison: a point exactly on the circle of radius two stays in.
    function bit beyond_radius(input longint re, input longint im);
      longint unsigned mag;
      mag = longint'(re * re) + longint'(im * im);
      return mag > mbet_pkg::FOUR_Q56;
    endfunction

    function mbet_pkg::out_t escape_count_of(input mbet_pkg::in_t px);
      longint c_re, c_im, z_re, z_im, nxt_re, nxt_im;
      int     count;
      mbet_pkg::out_t res;
      c_re = clamp_q428(org_re + longint'(px.pixel_col) * pitch_re);
      c_im = clamp_q428(org_im - longint'(px.pixel_row) * pitch_im);
      res.iter_value = mbet_pkg::MAX_ITER;
      res.owner_tag  = {1'b0, px.worker_id};
      if (beyond_radius(c_re, c_im)) begin
        res.iter_value = mbet_pkg::BLACK_VALUE;
        res.owner_tag  = mbet_pkg::WORKERS;
        return res;
      end
      z_re = c_re;
      z_im = c_im;
      // Count down from MAX_ITER; the shifts floor toward minus infinity.
      for (count = int'(mbet_pkg::MAX_ITER); count >= 0; count--) begin
        if (beyond_radius(z_re, z_im)) begin
          res.iter_value = count[mbet_pkg::ITER_W-1:0];
          break;
        end
        nxt_re = ((z_re * z_re - z_im * z_im) >>> 28) + c_re;
        nxt_im = ((z_re * z_im) >>> 27) + c_im;
        z_re = clamp_q428(nxt_re);
        z_im = clamp_q428(nxt_im);
      end
      return res;
    endfunction

    function void note_pixel(input mbet_pkg::in_t px);
      pending_escapes.push_back(escape_count_of(px));
    endfunction

    function void check_result(input mbet_pkg::out_t got);
      mbet_pkg::out_t want;
      if (pending_escapes.size() == 0) begin
        $error("unexpected result: iter_value %0d owner_tag %0d",
               got.iter_value, got.owner_tag);
        faults++;
        return;
      end
      want = pending_escapes.pop_front();
      if (got.iter_value !== want.iter_value) begin
        $error("iter_value: expected %0d, actual %0d", want.iter_value, got.iter_value);
        faults++;
      end
      if (got.owner_tag !== want.owner_tag) begin
        $error("owner_tag: expected %0d, actual %0d", want.owner_tag, got.owner_tag);
        faults++;
      end
    endfunction

    function int pending();
      return pending_escapes.size();
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  mbet_pkg::in_t                  in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  mbet_pkg::out_t                 out_data;
  logic                           cfg_we    = 1'b0;
  logic [mbet_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mbet_pkg::COORD_W-1:0]   cfg_data  = '0;

  escape_scoreboard sb;
  bit calm = 1'b0;
  int stall_left = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  mandelbrot_escape_time_pixel dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one, none while calm.
  function automatic int gap_len();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  // Result side: check every accepted result, then pick the next ready level.
  // One long hold-off lets the block fill up and push back on requests.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
      results_seen++;
      if (results_seen == HOLD_AT) begin
        stall_left = HOLD_CYCLES;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = gap_len();
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one request and hold it until accepted, then idle for a random gap, which may be empty.
  task automatic send_pixel(input mbet_pkg::in_t px);
    int gap;
    in_data  <= px;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(px);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and let every owed result come back.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write enable stays high across back-to-back writes.
  task automatic write_reg(input logic [mbet_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mbet_pkg::COORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Load a full view window plus one write to an unused index.
  task automatic load_view(input int o_re, input int o_im, input int s_re, input int s_im);
    write_reg(mbet_pkg::REG_ORIGIN_RE, o_re);
    write_reg(mbet_pkg::REG_ORIGIN_IM, o_im);
    write_reg(mbet_pkg::REG_STEP_RE, s_re);
    write_reg(mbet_pkg::REG_STEP_IM, s_im);
    write_reg(mbet_pkg::CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)),
              $urandom());
    cfg_we <= 1'b0;
  endtask

  // Random pixels under one view, with calm stretches now and then.
  task automatic run_view(input int o_re, input int o_im, input int s_re, input int s_im,
                          input int count);
    mbet_pkg::in_t px;
    quiesce();
    load_view(o_re, o_im, s_re, s_im);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) calm <= ($urandom_range(0, 4) == 0);
      px.pixel_col = 8'($urandom_range(0, 255));
      px.pixel_row = 8'($urandom_range(0, 255));
      px.worker_id = 4'($urandom_range(0, 15));
      send_pixel(px);
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default window spans -2..2 on both axes at 4/255 per pixel.
    send_pixel(mbet_pkg::in_t'{8'd0, 8'd0, 4'd0});       // corner, outside radius two
    send_pixel(mbet_pkg::in_t'{8'd255, 8'd255, 4'd15});  // far corner, outside
    send_pixel(mbet_pkg::in_t'{8'd128, 8'd128, 4'd1});   // near the origin, never escapes
    send_pixel(mbet_pkg::in_t'{8'd0, 8'd128, 4'd2});     // c near -2
    send_pixel(mbet_pkg::in_t'{8'd96, 8'd128, 4'd3});    // c near -0.5
    send_pixel(mbet_pkg::in_t'{8'd144, 8'd128, 4'd4});   // c near 0.25, the cusp
    send_pixel(mbet_pkg::in_t'{8'd145, 8'd128, 4'd5});   // further past the cusp
    send_pixel(mbet_pkg::in_t'{8'd128, 8'd64, 4'd6});    // c near i
    send_pixel(mbet_pkg::in_t'{8'd128, 8'd192, 4'd7});   // c near -i
    send_pixel(mbet_pkg::in_t'{8'd64, 8'd128, 4'd8});    // c near -1
    send_pixel(mbet_pkg::in_t'{8'd16, 8'd128, 4'd9});    // c near -1.75
    send_pixel(mbet_pkg::in_t'{8'd200, 8'd30, 4'd10});

    // Unit grid around 2 + 2i with a negative real step: points on the circle.
    quiesce();
    load_view(32'h2000_0000, 32'h2000_0000, 32'hF000_0000, 32'h1000_0000);
    send_pixel(mbet_pkg::in_t'{8'd0, 8'd2, 4'd11});      // c = 2, escapes on the next check
    send_pixel(mbet_pkg::in_t'{8'd4, 8'd2, 4'd12});      // c = -2
    send_pixel(mbet_pkg::in_t'{8'd2, 8'd0, 4'd13});      // c = 2i
    send_pixel(mbet_pkg::in_t'{8'd2, 8'd4, 4'd14});      // c = -2i
    send_pixel(mbet_pkg::in_t'{8'd2, 8'd2, 4'd15});      // c = 0

    // Extreme registers: coordinates clamp high on one axis, low on the other.
    quiesce();
    load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pixel(mbet_pkg::in_t'{8'd0, 8'd0, 4'd0});
    send_pixel(mbet_pkg::in_t'{8'd255, 8'd255, 4'd3});
    send_pixel(mbet_pkg::in_t'{8'd255, 8'd0, 4'd5});
    send_pixel(mbet_pkg::in_t'{8'd0, 8'd255, 4'd9});
    quiesce();
    load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_pixel(mbet_pkg::in_t'{8'd0, 8'd0, 4'd2});
    send_pixel(mbet_pkg::in_t'{8'd255, 8'd255, 4'd12});
    send_pixel(mbet_pkg::in_t'{8'd255, 8'd0, 4'd6});
    send_pixel(mbet_pkg::in_t'{8'd0, 8'd255, 4'd10});

    // Random pixels over a range of windows, the deep ones rich in long orbits.
    run_view(-536870912, 536870912, 4210752, 4210752, 200);
    run_view(-402653184, 268435456, 2097152, 2097152, 180);
    run_view(-201326592, 26843546, 134218, 134218, 180);
    repeat (2) begin
      run_view(int'($urandom_range(0, 32'h3000_0000)) - 32'h2800_0000,
               int'($urandom_range(0, 32'h2800_0000)) - 32'h0800_0000,
               int'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000,
               int'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000, 150);
    end
    run_view($urandom(), $urandom(), $urandom(), $urandom(), 60);

    quiesce();
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/mbet_pkg.sv
src/mbet_cfg_regs.sv
src/mbet_mul_unit.sv
src/mandelbrot_escape_time_pixel.sv
verif/mandelbrot_escape_time_pixel_tb.sv
